// ===== design/prti_pkg.sv =====
`timescale 1ns / 1ps

package prti_pkg;

    localparam int PRTI_VALUE_WIDTH = 16;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ZERO_COEFF = 2'd1;
    localparam logic [1:0] STATUS_DIV_ZERO   = 2'd2;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_start_num;
        logic div_start_den;
        logic div_step;
        logic out_load;
    } prti_cmd_t;

    typedef struct packed {
        logic special;
        logic gcd_done;
        logic div_done;
    } prti_sts_t;

endpackage

// ===== design/power_rule_term_integrator.sv =====
`timescale 1ns / 1ps
// an accepted beat goes through the check, the binary gcd loop and two restoring divisions
// (numerator, then denominator) before the result is loaded into the output register
// zero coefficient or division by zero skip straight to the output; one term is worked on at a time
// a new beat is taken the cycle after the previous result is loaded into the output register
// aresetn is synchronous, active low; it clears the controller and the output valid

module power_rule_term_integrator
    import prti_pkg::*;
#(
    parameter int VALUE_WIDTH = PRTI_VALUE_WIDTH,
    localparam int IN_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * VALUE_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // term_coefficient, term_exponent
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // fraction_numerator, fraction_denominator, is_negative, raised_exponent
    output logic [OUT_W-1:0]   m_tdata,
    // status
    output logic [1:0]         m_tuser
);

    prti_cmd_t cmd;
    prti_sts_t sts;

    logic [VALUE_WIDTH-1:0]        fraction_numerator, fraction_denominator;
    logic                          is_negative;
    logic signed [VALUE_WIDTH-1:0] raised_exponent;

    prti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    prti_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk                 (aclk),
        .term_coefficient     (s_tdata[VALUE_WIDTH-1:0]),
        .term_exponent        (s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
        .cmd                  (cmd),
        .sts                  (sts),
        .fraction_numerator   (fraction_numerator),
        .fraction_denominator (fraction_denominator),
        .is_negative          (is_negative),
        .raised_exponent      (raised_exponent),
        .status               (m_tuser)
    );

    assign m_tdata = OUT_W'({raised_exponent, is_negative,
                             fraction_denominator, fraction_numerator});

endmodule

// ===== design/prti_ctrl.sv =====
`timescale 1ns / 1ps

module prti_ctrl
    import prti_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output prti_cmd_t cmd,
    input  prti_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD,
        ST_DIV_NUM,
        ST_DEN_START,
        ST_DIV_DEN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.load = s_tvalid;
            ST_CHECK:     ;
            ST_GCD: begin
                if (sts.gcd_done) begin
                    cmd.div_start_num = 1'b1;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_NUM:   cmd.div_step = 1'b1;
            ST_DEN_START: cmd.div_start_den = 1'b1;
            ST_DIV_DEN:   cmd.div_step = 1'b1;
            ST_FINISH:    cmd.out_load = !m_tvalid_reg || m_tready;
            default:      ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    state_reg <= sts.special ? ST_FINISH : ST_GCD;
                end
                ST_GCD: begin
                    if (sts.gcd_done) begin
                        state_reg <= ST_DIV_NUM;
                    end
                end
                ST_DIV_NUM: begin
                    if (sts.div_done) begin
                        state_reg <= ST_DEN_START;
                    end
                end
                ST_DEN_START: state_reg <= ST_DIV_DEN;
                ST_DIV_DEN: begin
                    if (sts.div_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (cmd.out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted beat did not start a term");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    a_gcd_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gcd_step |-> !sts.gcd_done)
        else $error("gcd stepped after finishing");

endmodule

// ===== design/prti_datapath.sv =====
`timescale 1ns / 1ps

module prti_datapath
    import prti_pkg::*;
#(
    parameter int VALUE_WIDTH = PRTI_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic signed [VALUE_WIDTH-1:0] term_coefficient,
    input  logic signed [VALUE_WIDTH-1:0] term_exponent,
    input  prti_cmd_t                     cmd,
    output prti_sts_t                     sts,
    output logic        [VALUE_WIDTH-1:0] fraction_numerator,
    output logic        [VALUE_WIDTH-1:0] fraction_denominator,
    output logic                          is_negative,
    output logic signed [VALUE_WIDTH-1:0] raised_exponent,
    output logic        [1:0]             status
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);
    localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

    logic [W-1:0]        a_reg, b_reg, num_src_reg, den_src_reg, g_reg;
    logic [CNT_W-1:0]    k_reg, cnt_reg;
    logic [W-1:0]        rem_reg, quo_reg, num_res_reg, den_res_reg;
    logic                div_den_reg, neg_reg;
    logic [1:0]          status_reg;
    logic signed [W-1:0] raised_reg;

    logic [W-1:0]        fraction_numerator_reg, fraction_denominator_reg;
    logic                is_negative_reg;
    logic signed [W-1:0] raised_exponent_reg;
    logic [1:0]          status_out_reg;

    logic signed [W-1:0] raised_next;
    logic [W-1:0]        mag_c, mag_r;
    logic [W-1:0]        a_next, b_next;
    logic [CNT_W-1:0]    k_next;
    logic [W:0]          div_trial, div_diff;
    logic                div_ge;
    logic [W-1:0]        rem_next, quo_next;

    always_comb begin
        raised_next = (term_exponent == MAX_POS) ? MAX_POS : term_exponent + W'(1);
        mag_c = term_coefficient[W-1] ? W'(-term_coefficient) : W'(term_coefficient);
        mag_r = raised_next[W-1] ? W'(-raised_next) : W'(raised_next);
    end

    // binary gcd, one reduction per cycle
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        priority if (!a_reg[0] && !b_reg[0]) begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + CNT_W'(1);
        end else if (!a_reg[0]) begin
            a_next = a_reg >> 1;
        end else if (!b_reg[0]) begin
            b_next = b_reg >> 1;
        end else if (a_reg >= b_reg) begin
            a_next = (a_reg - b_reg) >> 1;
        end else begin
            b_next = (b_reg - a_reg) >> 1;
        end
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        div_trial = {rem_reg, quo_reg[W-1]};
        div_diff  = div_trial - {1'b0, g_reg};
        div_ge    = div_trial >= {1'b0, g_reg};
        rem_next  = div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
        quo_next  = {quo_reg[W-2:0], div_ge};
    end

    assign sts.special  = (status_reg != STATUS_OK);
    assign sts.gcd_done = (a_reg == '0) || (b_reg == '0);
    assign sts.div_done = (cnt_reg == CNT_LAST);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg       <= mag_c;
            b_reg       <= mag_r;
            k_reg       <= '0;
            num_src_reg <= mag_c;
            den_src_reg <= mag_r;
            raised_reg  <= raised_next;
            neg_reg     <= term_coefficient[W-1] ^ raised_next[W-1];
            if (term_coefficient == '0) begin
                status_reg <= STATUS_ZERO_COEFF;
            end else if (raised_next == '0) begin
                status_reg <= STATUS_DIV_ZERO;
            end else begin
                status_reg <= STATUS_OK;
            end
        end
        if (cmd.gcd_step) begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end
        if (cmd.div_start_num || cmd.div_start_den) begin
            rem_reg     <= '0;
            cnt_reg     <= '0;
            div_den_reg <= cmd.div_start_den;
            quo_reg     <= cmd.div_start_den ? den_src_reg : num_src_reg;
        end
        if (cmd.div_start_num) begin
            g_reg <= (a_reg | b_reg) << k_reg;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (sts.div_done) begin
                if (div_den_reg) begin
                    den_res_reg <= quo_next;
                end else begin
                    num_res_reg <= quo_next;
                end
            end
        end
        if (cmd.out_load) begin
            raised_exponent_reg <= raised_reg;
            status_out_reg      <= status_reg;
            unique case (status_reg)
                STATUS_OK: begin
                    fraction_numerator_reg   <= num_res_reg;
                    fraction_denominator_reg <= den_res_reg;
                    is_negative_reg          <= neg_reg;
                end
                STATUS_ZERO_COEFF: begin
                    fraction_numerator_reg   <= '0;
                    fraction_denominator_reg <= W'(1);
                    is_negative_reg          <= 1'b0;
                end
                default: begin
                    fraction_numerator_reg   <= '0;
                    fraction_denominator_reg <= '0;
                    is_negative_reg          <= 1'b0;
                end
            endcase
        end
    end

    assign fraction_numerator   = fraction_numerator_reg;
    assign fraction_denominator = fraction_denominator_reg;
    assign is_negative          = is_negative_reg;
    assign raised_exponent      = raised_exponent_reg;
    assign status               = status_out_reg;

endmodule
